// ===== rtl/core/kms_pkg.sv =====
// Shared constants, types and helpers for the key matrix scanner.
package kms_pkg;

    localparam int MAX_COLS = 16;
    localparam int MAX_ROWS = 16;
    localparam int HW_LIMIT = 16;

    localparam int COL_LIM = (MAX_COLS < HW_LIMIT) ? MAX_COLS : HW_LIMIT;
    localparam int ROW_LIM = (MAX_ROWS < HW_LIMIT) ? MAX_ROWS : HW_LIMIT;

    localparam int ROWS_W  = 16;
    localparam int COL_W   = 4;
    localparam int ROW_IDX_W = 4;
    localparam int CNT_W   = 5;
    localparam int POS_W   = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [CNT_W-1:0] COUNT_RESET = 5'd16;

    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_PRESSES = 2'd2;

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROWS_W-1:0] pressed;
        logic [COL_W-1:0]  next_col;
        logic              done;
        logic [CNT_W-1:0]  cols;
        logic              report;
    } t_desc;

    typedef struct packed {
        logic [COL_W-1:0]  scanned_column;
        logic [ROWS_W-1:0] pressed_rows;
        logic [POS_W-1:0]  key_position;
        logic              key_valid;
        logic [COL_W-1:0]  drive_column;
        logic              frame_done;
        logic              last;
    } t_res;

    typedef struct packed {
        logic              valid;
        logic [CFG_IDX_W-1:0] index;
        logic [CNT_W-1:0]  data;
    } t_cfg_wr;

    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
                                                     input logic [CNT_W-1:0] lim);
        logic [CNT_W-1:0] r;
        if (v == '0) begin
            r = CNT_W'(1);
        end else if (v > lim) begin
            r = lim;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/kms_front.sv =====
// Front end: holds configuration and the column counter, classifies each sample.
module kms_front import kms_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg_wr           i_cfg,
    input  logic              i_push,
    input  logic [ROWS_W-1:0] i_row_levels,
    input  logic              i_q_full,
    output logic              o_q_wr,
    output t_desc             o_desc
);

    logic [CNT_W-1:0] r_col_count, n_col_count;
    logic [CNT_W-1:0] r_row_count, n_row_count;
    logic             r_report, n_report;
    logic [COL_W-1:0] r_cur_col, n_cur_col;

    logic [CNT_W-1:0]  cols, rows;
    logic [ROWS_W-1:0] mask;
    logic [COL_W-1:0]  col;
    logic [CNT_W-1:0]  col_inc;
    logic              done;

    always_comb begin
        cols = clamp_count(r_col_count, CNT_W'(COL_LIM));
        rows = clamp_count(r_row_count, CNT_W'(ROW_LIM));
        for (int i = 0; i < ROWS_W; i++) begin
            mask[i] = (CNT_W'(i) < rows);
        end
        col     = ({1'b0, r_cur_col} >= cols) ? '0 : r_cur_col;
        col_inc = {1'b0, col} + CNT_W'(1);
        done    = (col_inc >= cols);

        o_desc.col      = col;
        o_desc.pressed  = ~i_row_levels & mask;
        o_desc.next_col = done ? '0 : col_inc[COL_W-1:0];
        o_desc.done     = done;
        o_desc.cols     = cols;
        o_desc.report   = r_report;

        o_q_wr = i_push && !i_q_full;

        n_col_count = r_col_count;
        n_row_count = r_row_count;
        n_report    = r_report;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_COL_COUNT:      n_col_count = i_cfg.data;
                CFG_ROW_COUNT:      n_row_count = i_cfg.data;
                CFG_REPORT_PRESSES: n_report    = i_cfg.data[0];
                default:            ;
            endcase
        end
        n_cur_col = o_q_wr ? o_desc.next_col : r_cur_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_count <= COUNT_RESET;
            r_row_count <= COUNT_RESET;
            r_report    <= 1'b0;
            r_cur_col   <= '0;
        end else begin
            r_col_count <= n_col_count;
            r_row_count <= n_row_count;
            r_report    <= n_report;
            r_cur_col   <= n_cur_col;
        end
    end

endmodule

// ===== rtl/core/kms_queue.sv =====
// Two-entry request queue between the front end and the row walker.
module kms_queue import kms_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr,
    input  t_desc i_data,
    input  logic  i_rd,
    output logic  o_full,
    output logic  o_nonempty,
    output t_desc o_data
);

    t_desc      r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_cnt;

    assign o_full     = (r_cnt == 2'd2);
    assign o_nonempty = (r_cnt != 2'd0);
    assign o_data     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_rd) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_wr, i_rd})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/core/kms_back.sv =====
// Back end: walks the pressed rows of one request and holds the output register.
module kms_back import kms_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_q_nonempty,
    input  t_desc i_q_data,
    output logic  o_q_rd,
    input  logic  i_pop,
    output logic  o_out_valid,
    output t_res  o_res
);

    t_desc               r_desc, n_desc;
    logic                r_busy, n_busy;
    logic [ROW_IDX_W-1:0] r_y, n_y;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic                r_out_valid;
    t_res                r_res;

    logic              slot, emit, simple, hi_any;
    logic [ROWS_W-1:0] above;
    t_res              res;

    always_comb begin
        for (int i = 0; i < ROWS_W; i++) begin
            above[i] = (ROW_IDX_W'(i) > r_y) && (i < ROWS_W);
        end
        hi_any = |(r_desc.pressed & above);
        simple = !r_desc.report || (r_desc.pressed == '0);
        slot   = !r_out_valid || i_pop;

        res.scanned_column = r_desc.col;
        res.pressed_rows   = r_desc.pressed;
        res.key_position   = simple ? '0 : r_pos;
        res.key_valid      = !simple;
        res.drive_column   = r_desc.next_col;
        res.frame_done     = r_desc.done;
        res.last           = simple ? 1'b1 : !hi_any;

        n_desc = r_desc;
        n_busy = r_busy;
        n_y    = r_y;
        n_pos  = r_pos;
        o_q_rd = 1'b0;
        emit   = 1'b0;

        if (!r_busy) begin
            if (i_q_nonempty) begin
                o_q_rd = 1'b1;
                n_desc = i_q_data;
                n_busy = 1'b1;
                n_y    = '0;
                n_pos  = POS_W'(i_q_data.col);
            end
        end else if (simple) begin
            if (slot) begin
                emit   = 1'b1;
                n_busy = 1'b0;
            end
        end else if (r_desc.pressed[r_y]) begin
            if (slot) begin
                emit = 1'b1;
                if (!hi_any) begin
                    n_busy = 1'b0;
                end else begin
                    n_y   = r_y + ROW_IDX_W'(1);
                    n_pos = r_pos + POS_W'(r_desc.cols);
                end
            end
        end else begin
            n_y   = r_y + ROW_IDX_W'(1);
            n_pos = r_pos + POS_W'(r_desc.cols);
        end
    end

    always_ff @(posedge i_clk) begin
        r_desc <= n_desc;
        r_y    <= n_y;
        r_pos  <= n_pos;
        if (emit) begin
            r_res <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

endmodule

// ===== rtl/core/key_matrix_scanner_core.sv =====
// Key matrix scanner top level: front end, request queue and row walker.
// The row walker loads one request at a time from a two-entry queue that decouples input; with
// reporting on and a key pressed it steps row by row up to the highest pressed row and emits
// a result per pressed row, else a single result; it stalls while its result is not popped.
// Reset (synchronous, active low) sets both counts to 16, reporting off, column 0,
// and empties the queue and the output register.
module key_matrix_scanner_core import kms_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CNT_W-1:0]     i_cfg_data,
    input  logic                 push,
    output logic                 full,
    input  logic [ROWS_W-1:0]    i_row_levels,
    output logic                 empty,
    input  logic                 pop,
    output logic [COL_W-1:0]     o_scanned_column,
    output logic [ROWS_W-1:0]    o_pressed_rows,
    output logic [POS_W-1:0]     o_key_position,
    output logic                 o_key_valid,
    output logic [COL_W-1:0]     o_drive_column,
    output logic                 o_frame_done,
    output logic                 o_last
);

    t_cfg_wr cfg;
    t_desc   wr_desc, rd_desc;
    t_res    res;
    logic    q_wr, q_rd, q_full, q_nonempty, out_valid;

    assign o_cfg_ready = 1'b1;
    assign cfg.valid   = i_cfg_valid;
    assign cfg.index   = i_cfg_index;
    assign cfg.data    = i_cfg_data;

    kms_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_push       (push),
        .i_row_levels (i_row_levels),
        .i_q_full     (q_full),
        .o_q_wr       (q_wr),
        .o_desc       (wr_desc)
    );

    kms_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (q_wr),
        .i_data     (wr_desc),
        .i_rd       (q_rd),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_data     (rd_desc)
    );

    kms_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_nonempty (q_nonempty),
        .i_q_data     (rd_desc),
        .o_q_rd       (q_rd),
        .i_pop        (pop),
        .o_out_valid  (out_valid),
        .o_res        (res)
    );

    assign full             = q_full;
    assign empty            = !out_valid;
    assign o_scanned_column = res.scanned_column;
    assign o_pressed_rows   = res.pressed_rows;
    assign o_key_position   = res.key_position;
    assign o_key_valid      = res.key_valid;
    assign o_drive_column   = res.drive_column;
    assign o_frame_done     = res.frame_done;
    assign o_last           = res.last;

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the key matrix scanner core: queue-style drive and result checking.
`timescale 1ns / 100ps

module tb_top;
    import kms_pkg::*;

    localparam int RESULT_LAT   = 2;
    localparam int RANDOM_ITEMS = 230;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CNT_W-1:0]     i_cfg_data = '0;
    logic                 push = 1'b0;
    logic                 full;
    logic [ROWS_W-1:0]    i_row_levels = '1;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [COL_W-1:0]     o_scanned_column;
    logic [ROWS_W-1:0]    o_pressed_rows;
    logic [POS_W-1:0]     o_key_position;
    logic                 o_key_valid;
    logic [COL_W-1:0]     o_drive_column;
    logic                 o_frame_done;
    logic                 o_last;

    bit in_calm  = 1'b0;
    bit out_calm = 1'b0;
    int requests_sent = 0;
    int cfg_writes    = 0;
    int settings_used = 0;

    class key_scan_scoreboard;
        logic [CNT_W-1:0]  col_count_q;
        logic [CNT_W-1:0]  row_count_q;
        logic              report_q;
        logic [COL_W-1:0]  cur_col;
        logic [ROWS_W-1:0] key_map [HW_LIMIT];
        t_res              key_reports [$];
        int                mismatches;
        int                checked;

        function new();
            col_count_q = COUNT_RESET;
            row_count_q = COUNT_RESET;
            report_q    = 1'b0;
            cur_col     = '0;
            foreach (key_map[i]) key_map[i] = '0;
            mismatches  = 0;
            checked     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] data);
            case (idx)
                CFG_COL_COUNT: col_count_q = data;
                CFG_ROW_COUNT: row_count_q = data;
                CFG_REPORT_PRESSES: report_q = data[0];
                default: ;
            endcase
        endfunction

        function int unsigned usable_count(logic [CNT_W-1:0] v, int unsigned lim);
            if (v == '0) return 1;
            if (32'(v) > lim) return lim;
            return 32'(v);
        endfunction

        function void scan_column(logic [ROWS_W-1:0] levels);
            int unsigned       cols;
            int unsigned       rows;
            int unsigned       col;
            logic [ROWS_W-1:0] mask;
            logic [ROWS_W-1:0] pressed;
            logic [COL_W-1:0]  next_col;
            logic              done;
            t_res              r;
            cols = usable_count(col_count_q, COL_LIM);
            rows = usable_count(row_count_q, ROW_LIM);
            mask = (rows >= ROWS_W) ? '1 : ROWS_W'((32'd1 << rows) - 1);
            col = 32'(cur_col);
            if (col >= cols) col = 0;
            if (col == 0) begin
                foreach (key_map[i]) key_map[i] = '0;
            end
            pressed = ~levels & mask;
            key_map[col] = pressed;
            done = (col + 1 >= cols);
            next_col = done ? '0 : COL_W'(col + 1);
            cur_col = next_col;
            r.scanned_column = COL_W'(col);
            r.pressed_rows   = pressed;
            r.drive_column   = next_col;
            r.frame_done     = done;
            if (report_q && pressed != '0) begin
                for (int y = 0; y < rows; y++) begin
                    if (pressed[y]) begin
                        r.key_position = POS_W'(col + y * cols);
                        r.key_valid    = 1'b1;
                        r.last         = ((pressed >> (y + 1)) == '0);
                        key_reports.push_back(r);
                    end
                end
            end else begin
                r.key_position = '0;
                r.key_valid    = 1'b0;
                r.last         = 1'b1;
                key_reports.push_back(r);
            end
        endfunction

        function void compare(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_report(t_res got);
            t_res want;
            if (key_reports.size() == 0) begin
                $error("Unexpected result for column %0d with no request waiting",
                       got.scanned_column);
                mismatches++;
                return;
            end
            want = key_reports.pop_front();
            checked++;
            compare("scanned_column", 32'(want.scanned_column), 32'(got.scanned_column));
            compare("pressed_rows", 32'(want.pressed_rows), 32'(got.pressed_rows));
            compare("key_position", 32'(want.key_position), 32'(got.key_position));
            compare("key_valid", 32'(want.key_valid), 32'(got.key_valid));
            compare("drive_column", 32'(want.drive_column), 32'(got.drive_column));
            compare("frame_done", 32'(want.frame_done), 32'(got.frame_done));
            compare("last", 32'(want.last), 32'(got.last));
        endfunction

        function int outstanding();
            return key_reports.size();
        endfunction
    endclass

    key_scan_scoreboard board;

    key_matrix_scanner_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .push             (push),
        .full             (full),
        .i_row_levels     (i_row_levels),
        .empty            (empty),
        .pop              (pop),
        .o_scanned_column (o_scanned_column),
        .o_pressed_rows   (o_pressed_rows),
        .o_key_position   (o_key_position),
        .o_key_valid      (o_key_valid),
        .o_drive_column   (o_drive_column),
        .o_frame_done     (o_frame_done),
        .o_last           (o_last)
    );

    always #10 i_clk = ~i_clk;

    task automatic push_rows(input logic [ROWS_W-1:0] levels);
        int gap;
        gap = in_calm ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_row_levels <= levels;
        do @(posedge i_clk); while (full);
        board.scan_column(levels);
        requests_sent++;
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(idx, data);
        cfg_writes++;
    endtask

    task automatic configure(input logic [CNT_W-1:0] cols, input logic [CNT_W-1:0] rows,
                             input logic report, input bit spare);
        write_cfg(CFG_COL_COUNT, cols);
        write_cfg(CFG_ROW_COUNT, rows);
        write_cfg(CFG_REPORT_PRESSES, {{(CNT_W-1){1'b0}}, report});
        if (spare) write_cfg(CFG_SPARE, CNT_W'($urandom_range(0, 31)));
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic settle();
        push <= 1'b0;
        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (RESULT_LAT + 2) @(posedge i_clk);
    endtask

    function automatic logic [CNT_W-1:0] pick_count();
        logic [CNT_W-1:0] v;
        case ($urandom_range(0, 7))
            0: v = CNT_W'($urandom_range(0, 31));
            1: v = CNT_W'(16);
            2: v = CNT_W'(1);
            default: v = CNT_W'($urandom_range(1, 8));
        endcase
        return v;
    endfunction

    function automatic logic [ROWS_W-1:0] pick_levels();
        logic [ROWS_W-1:0] v;
        case ($urandom_range(0, 5))
            0: v = '1;
            1: v = ~(ROWS_W'(1) << $urandom_range(0, 15));
            2: v = ~(ROWS_W'($urandom) & ROWS_W'($urandom) & ROWS_W'($urandom));
            5: v = '0;
            default: v = ROWS_W'($urandom);
        endcase
        return v;
    endfunction

    initial begin
        t_res got;
        int   gap;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = out_calm ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            got.scanned_column = o_scanned_column;
            got.pressed_rows   = o_pressed_rows;
            got.key_position   = o_key_position;
            got.key_valid      = o_key_valid;
            got.drive_column   = o_drive_column;
            got.frame_done     = o_frame_done;
            got.last           = o_last;
            board.check_report(got);
        end
    end

    initial begin
        int random_left;
        int n;
        board = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: all sixteen rows and columns, reporting off.
        push_rows(16'hFFFF);
        push_rows(16'h0000);
        push_rows(16'hAAAA);
        push_rows(16'h5555);
        settle();

        configure(CNT_W'(16), CNT_W'(16), 1'b1, 1'b0);
        push_rows(16'h0000);
        push_rows(16'hFFFF);
        push_rows(16'h7FFE);
        settle();

        // The column now lies past the lowered count, so the scan restarts at zero.
        configure(CNT_W'(3), CNT_W'(5), 1'b1, 1'b0);
        push_rows(16'h0000);
        push_rows(16'hFFFF);
        push_rows(16'hFFEE);
        push_rows(16'h0010);
        settle();

        configure(CNT_W'(0), CNT_W'(0), 1'b1, 1'b1);
        push_rows(16'h0000);
        push_rows(16'hFFFE);
        push_rows(16'hFFFF);
        settle();

        configure(CNT_W'(31), CNT_W'(31), 1'b1, 1'b0);
        push_rows(16'h0000);
        push_rows(16'h7FFF);
        push_rows(16'h1234);
        settle();

        configure(CNT_W'(1), CNT_W'(16), 1'b0, 1'b0);
        push_rows(16'h0000);
        push_rows(16'hFFFF);
        settle();

        random_left = RANDOM_ITEMS;
        while (random_left > 0) begin
            n = $urandom_range(12, 30);
            if (n > random_left) n = random_left;
            settle();
            configure(pick_count(), pick_count(), ($urandom_range(0, 3) != 0),
                      ($urandom_range(0, 3) == 0));
            in_calm  = ($urandom_range(0, 3) == 0);
            out_calm = ($urandom_range(0, 3) == 0);
            repeat (n) push_rows(pick_levels());
            random_left -= n;
        end

        push <= 1'b0;
        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (RESULT_LAT + 17) @(posedge i_clk);

        $display("Summary: %0d row samples pushed, %0d results checked, %0d mismatches.",
                 requests_sent, board.checked, board.mismatches);
        $display("Summary: %0d register writes across %0d scan settings.",
                 cfg_writes, settings_used);
        if (board.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/kms_pkg.sv
rtl/core/kms_front.sv
rtl/core/kms_queue.sv
rtl/core/kms_back.sv
rtl/core/key_matrix_scanner_core.sv
test/tb_top.sv
